### design/newton_bisection_root_step_macros.svh
// Assertion helpers for the root-step design file.
`ifndef NEWTON_BISECTION_ROOT_STEP_MACROS_SVH
`define NEWTON_BISECTION_ROOT_STEP_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset
`define NBR_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define NBR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/nbr_pkg.sv
package nbr_pkg;

   localparam int VW     = 32;
   localparam int FB     = 16;
   localparam int DVD_W  = VW + FB;
   localparam int IT_W   = 16;
   localparam int TOL_W  = 31;
   localparam int LIM_W  = 8;

   typedef logic signed [VW-1:0] val_type;

   localparam val_type VMAX      = {1'b0, {(VW-1){1'b1}}};
   localparam val_type VMIN      = {1'b1, {(VW-1){1'b0}}};
   localparam val_type PROBE_DIV = val_type'(10000);

   typedef struct packed {
      logic    start_req;
      val_type initial_guess;
      val_type f_value;
      val_type derivative;
   } req_type;

   typedef struct packed {
      val_type          next_x;
      logic             done_res;
      logic [1:0]       error_code;
      logic [IT_W-1:0]  iteration;
   } rsp_type;

   typedef enum logic [1:0] {
      CSR_LOWER = 2'd0,
      CSR_UPPER = 2'd1,
      CSR_TOL   = 2'd2,
      CSR_LIMIT = 2'd3
   } csr_index_type;

   localparam logic [1:0] ERR_OK         = 2'd0;
   localparam logic [1:0] ERR_BOUNDS     = 2'd1;
   localparam logic [1:0] ERR_GUESS      = 2'd2;
   localparam logic [1:0] ERR_NO_BRACKET = 2'd3;

   localparam logic [2:0] MODE_NEWTON     = 3'd0;
   localparam logic [2:0] MODE_PROBE_HI   = 3'd1;
   localparam logic [2:0] MODE_PROBE_HI_K = 3'd2;
   localparam logic [2:0] MODE_PROBE_LO   = 3'd3;
   localparam logic [2:0] MODE_PROBE_LO_K = 3'd4;
   localparam logic [2:0] MODE_BR_NEWTON  = 3'd5;
   localparam logic [2:0] MODE_BISECT     = 3'd6;

   // Command to the shared divider
   typedef struct packed {
      logic    start;
      logic    shift;   // 1: (num << FB) / den, 0: num / den
      val_type num;
      val_type den;
   } div_cmd_type;

   function automatic val_type sat_add(val_type a, val_type b);
      logic signed [VW:0] s;
      s = {a[VW-1], a} + {b[VW-1], b};
      if (s[VW] != s[VW-1]) return s[VW] ? VMIN : VMAX;
      return s[VW-1:0];
   endfunction

   function automatic val_type sat_sub(val_type a, val_type b);
      logic signed [VW:0] s;
      s = {a[VW-1], a} - {b[VW-1], b};
      if (s[VW] != s[VW-1]) return s[VW] ? VMIN : VMAX;
      return s[VW-1:0];
   endfunction

   // floor((a + b) / 2), exact
   function automatic val_type midpoint(val_type a, val_type b);
      logic signed [VW:0] s;
      s = {a[VW-1], a} + {b[VW-1], b};
      return s[VW:1];
   endfunction

   function automatic logic same_sign(val_type a, val_type b);
      return (a != '0) && (b != '0) && (a[VW-1] == b[VW-1]);
   endfunction

   function automatic logic opp_sign(val_type a, val_type b);
      return (a != '0) && (b != '0) && (a[VW-1] != b[VW-1]);
   endfunction

   function automatic logic [VW-1:0] mag(val_type v);
      logic [VW-1:0] u;
      u = v;
      return v[VW-1] ? (~u + 1'b1) : u;
   endfunction

endpackage

### design/nbr_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, saturating result
module nbr_div (
   input  logic                clock,
   input  logic                reset,
   input  nbr_pkg::div_cmd_type cmd,
   output logic                done,
   output nbr_pkg::val_type    quot
);

   localparam int CNT_W = $clog2(nbr_pkg::DVD_W + 1);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [nbr_pkg::DVD_W-1:0]   dvd_ff, dvd_in;
   logic [nbr_pkg::DVD_W-1:0]   q_ff, q_in;
   logic [nbr_pkg::VW-1:0]      rem_ff, rem_in;
   logic [nbr_pkg::VW-1:0]      den_ff, den_in;
   logic                        neg_ff, neg_in;
   logic [nbr_pkg::VW:0]        rem_sh;
   logic [nbr_pkg::VW:0]        rem_dif;
   logic                        ge;
   logic [nbr_pkg::VW-1:0]      nm;
   logic                        q_ovf;

   assign rem_sh  = {rem_ff, dvd_ff[nbr_pkg::DVD_W-1]};
   assign rem_dif = rem_sh - {1'b0, den_ff};
   assign ge      = (rem_sh >= {1'b0, den_ff});
   assign nm      = nbr_pkg::mag(cmd.num);

   // next-state of the iteration
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (cmd.start) begin
         neg_in = cmd.num[nbr_pkg::VW-1] ^ cmd.den[nbr_pkg::VW-1];
         den_in = nbr_pkg::mag(cmd.den);
         rem_in = '0;
         dvd_in = cmd.shift ? {nm, {nbr_pkg::FB{1'b0}}} : {{nbr_pkg::FB{1'b0}}, nm};
         cnt_in = CNT_W'(nbr_pkg::DVD_W);
         if (cmd.den == '0) begin
            // zero divisor saturates by the dividend's sign
            q_in    = (cmd.num == '0) ? '0 : '1;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            q_in    = '0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in = ge ? rem_dif[nbr_pkg::VW-1:0] : rem_sh[nbr_pkg::VW-1:0];
         dvd_in = dvd_ff << 1;
         q_in   = {q_ff[nbr_pkg::DVD_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   // saturate the magnitude into the signed range
   assign q_ovf = |q_ff[nbr_pkg::DVD_W-1:nbr_pkg::VW-1];

   always_comb begin
      if (neg_ff) begin
         quot = q_ovf ? nbr_pkg::VMIN : nbr_pkg::val_type'(~q_ff[nbr_pkg::VW-1:0] + 1'b1);
      end else begin
         quot = q_ovf ? nbr_pkg::VMAX : nbr_pkg::val_type'(q_ff[nbr_pkg::VW-1:0]);
      end
   end

   assign done = done_ff;

endmodule

### design/newton_bisection_root_step.sv
// Safeguarded Newton / bisection root finder, one step per request, signed Q16.16.
// Each request carries f (and f' or zero) at the last announced point; the
// response gives the next point, a done flag and an error code. One request is
// handled at a time. A request that finds the root, reports an error or only
// moves a bracket probe goes from S_EVAL straight to S_FIN. A Newton step waits
// in S_DIV for the shared bit-serial divider, which produces one of 48 quotient
// bits per cycle and runs twice in series for a secant step (derivative zero).
module newton_bisection_root_step (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  nbr_pkg::req_type      req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output nbr_pkg::rsp_type      rsp_data,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [nbr_pkg::VW-1:0] csr_wdata
);

`include "newton_bisection_root_step_macros.svh"

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EVAL = 4'b0010,
      S_DIV  = 4'b0100,
      S_FIN  = 4'b1000
   } state_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_FIRST,
      OP_DEFAULT,
      OP_BRACK,
      OP_PLAIN
   } op_type;

   state_type                      state_ff, state_in;
   op_type                         op_ff, op_in;
   nbr_pkg::val_type               lb_ff, lb_in, ub_ff, ub_in;
   logic [nbr_pkg::TOL_W-1:0]      tol_ff, tol_in;
   logic [nbr_pkg::LIM_W-1:0]      lim_ff, lim_in;
   nbr_pkg::val_type               f_ff, f_in, d_ff, d_in;
   nbr_pkg::val_type               cur_ff, cur_in, pp_ff, pp_in, pv_ff, pv_in;
   nbr_pkg::val_type               bl_ff, bl_in, bh_ff, bh_in;
   nbr_pkg::val_type               val_ff, val_in, vah_ff, vah_in, bw_ff, bw_in;
   nbr_pkg::val_type               xn_ff, xn_in;
   logic [2:0]                     mode_ff, mode_in;
   logic [nbr_pkg::IT_W-1:0]       iter_ff, iter_in;
   logic                           sec_ff, sec_in, probe_ff, probe_in;
   logic                           done_ff, done_in;
   logic [1:0]                     err_ff, err_in;
   logic [2*nbr_pkg::VW-1:0]       prod_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   nbr_pkg::rsp_type               rsp_ff, rsp_in;

   nbr_pkg::div_cmd_type           div_cmd;
   logic                           div_done;
   nbr_pkg::val_type               div_q;

   nbr_pkg::val_type               x, bw_first;
   logic [2:0]                     m;
   logic [1:0]                     err;
   logic [nbr_pkg::IT_W-1:0]       it;
   logic                           out_free, rej;
   logic [2*nbr_pkg::VW-1:0]       f_lhs;

   nbr_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .done  (div_done),
      .quot  (div_q)
   );

   assign bw_first = nbr_pkg::sat_sub(ub_ff, lb_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign f_lhs    = (2*nbr_pkg::VW)'(nbr_pkg::mag(f_ff)) << (nbr_pkg::FB + 1);
   assign rej      = (d_ff != '0) && (f_lhs > prod_ff);

   // sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      lb_in        = lb_ff;
      ub_in        = ub_ff;
      tol_in       = tol_ff;
      lim_in       = lim_ff;
      f_in         = f_ff;
      d_in         = d_ff;
      cur_in       = cur_ff;
      pp_in        = pp_ff;
      pv_in        = pv_ff;
      bl_in        = bl_ff;
      bh_in        = bh_ff;
      val_in       = val_ff;
      vah_in       = vah_ff;
      bw_in        = bw_ff;
      xn_in        = xn_ff;
      mode_in      = mode_ff;
      iter_in      = iter_ff;
      sec_in       = sec_ff;
      probe_in     = probe_ff;
      done_in      = done_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      div_cmd      = '0;
      x            = cur_ff;
      m            = mode_ff;
      err          = err_ff;
      it           = iter_ff;
      req_ready    = (state_ff == S_IDLE);

      // register writes
      if (csr_we) begin
         unique case (nbr_pkg::csr_index_type'(csr_index))
            nbr_pkg::CSR_LOWER: lb_in  = csr_wdata;
            nbr_pkg::CSR_UPPER: ub_in  = csr_wdata;
            nbr_pkg::CSR_TOL:   tol_in = csr_wdata[nbr_pkg::TOL_W-1:0];
            nbr_pkg::CSR_LIMIT: lim_in = csr_wdata[nbr_pkg::LIM_W-1:0];
            default:            lb_in  = lb_ff;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               f_in = req_data.f_value;
               d_in = req_data.derivative;
               if (req_data.start_req) begin
                  iter_in = '0;
                  cur_in  = req_data.initial_guess;
               end
               state_in = S_EVAL;
            end
         end

         S_EVAL: begin
            state_in = S_FIN;
            op_in    = OP_HOLD;
            done_in  = 1'b0;
            err_in   = nbr_pkg::ERR_OK;
            sec_in   = 1'b0;
            probe_in = 1'b0;
            xn_in    = cur_ff;
            if (nbr_pkg::mag(f_ff) <= {1'b0, tol_ff}) begin
               done_in = 1'b1;
            end else if (iter_ff == '0) begin
               // first step of a search
               if (lb_ff > ub_ff) begin
                  err_in = nbr_pkg::ERR_BOUNDS;
               end else if (cur_ff > ub_ff || cur_ff < lb_ff) begin
                  err_in = nbr_pkg::ERR_GUESS;
               end else begin
                  bl_in    = lb_ff;
                  bh_in    = ub_ff;
                  bw_in    = bw_first;
                  val_in   = '0;
                  vah_in   = '0;
                  pp_in    = cur_ff;
                  pv_in    = f_ff;
                  op_in    = OP_FIRST;
                  state_in = S_DIV;
                  div_cmd.start = 1'b1;
                  if (d_ff == '0) begin
                     probe_in      = 1'b1;
                     div_cmd.shift = 1'b0;
                     div_cmd.num   = bw_first;
                     div_cmd.den   = nbr_pkg::PROBE_DIV;
                  end else begin
                     div_cmd.shift = 1'b1;
                     div_cmd.num   = f_ff;
                     div_cmd.den   = d_ff;
                  end
               end
            end else begin
               unique case (mode_ff)
                  nbr_pkg::MODE_PROBE_HI: begin
                     op_in  = OP_PLAIN;
                     vah_in = f_ff;
                     if (nbr_pkg::opp_sign(f_ff, pv_ff)) begin
                        bl_in   = pp_ff;
                        val_in  = pv_ff;
                        bh_in   = cur_ff;
                        xn_in   = nbr_pkg::midpoint(pp_ff, cur_ff);
                        mode_in = nbr_pkg::MODE_BR_NEWTON;
                        bw_in   = nbr_pkg::sat_sub(cur_ff, pp_ff);
                     end else begin
                        bh_in   = pp_ff;
                        vah_in  = pv_ff;
                        xn_in   = bl_ff;
                        mode_in = nbr_pkg::MODE_PROBE_LO_K;
                        bw_in   = nbr_pkg::sat_sub(pp_ff, bl_ff);
                     end
                  end
                  nbr_pkg::MODE_PROBE_HI_K: begin
                     op_in  = OP_PLAIN;
                     vah_in = f_ff;
                     if (!nbr_pkg::same_sign(f_ff, val_ff)) begin
                        bl_in   = pp_ff;
                        val_in  = pv_ff;
                        xn_in   = nbr_pkg::midpoint(pp_ff, cur_ff);
                        bw_in   = nbr_pkg::sat_sub(bh_ff, pp_ff);
                        mode_in = nbr_pkg::MODE_BR_NEWTON;
                     end
                  end
                  nbr_pkg::MODE_PROBE_LO: begin
                     op_in  = OP_PLAIN;
                     val_in = f_ff;
                     if (nbr_pkg::opp_sign(f_ff, pv_ff)) begin
                        bh_in   = pp_ff;
                        vah_in  = pv_ff;
                        bl_in   = cur_ff;
                        xn_in   = nbr_pkg::midpoint(pp_ff, cur_ff);
                        mode_in = nbr_pkg::MODE_BR_NEWTON;
                        bw_in   = nbr_pkg::sat_sub(pp_ff, cur_ff);
                     end else begin
                        bl_in   = pp_ff;
                        val_in  = pv_ff;
                        xn_in   = bh_ff;
                        mode_in = nbr_pkg::MODE_PROBE_HI_K;
                        bw_in   = nbr_pkg::sat_sub(bh_ff, pp_ff);
                     end
                  end
                  nbr_pkg::MODE_PROBE_LO_K: begin
                     op_in  = OP_PLAIN;
                     val_in = f_ff;
                     if (!nbr_pkg::same_sign(f_ff, vah_ff)) begin
                        bh_in   = pp_ff;
                        vah_in  = pv_ff;
                        xn_in   = nbr_pkg::midpoint(pp_ff, cur_ff);
                        bw_in   = nbr_pkg::sat_sub(pp_ff, bl_ff);
                        mode_in = nbr_pkg::MODE_BR_NEWTON;
                     end
                  end
                  default: begin
                     // Newton or secant step, plain or bracketed
                     if (mode_ff == nbr_pkg::MODE_BR_NEWTON ||
                         mode_ff == nbr_pkg::MODE_BISECT) begin
                        op_in = OP_BRACK;
                        if (nbr_pkg::same_sign(val_ff, f_ff)) begin
                           bl_in  = cur_ff;
                           val_in = f_ff;
                           bw_in  = nbr_pkg::sat_sub(bh_ff, cur_ff);
                        end else if (nbr_pkg::same_sign(vah_ff, f_ff)) begin
                           bh_in  = cur_ff;
                           vah_in = f_ff;
                           bw_in  = nbr_pkg::sat_sub(cur_ff, bl_ff);
                        end
                     end else begin
                        op_in = OP_DEFAULT;
                     end
                     div_cmd.start = 1'b1;
                     div_cmd.shift = 1'b1;
                     if (d_ff != '0) begin
                        div_cmd.num = f_ff;
                        div_cmd.den = d_ff;
                     end else begin
                        sec_in      = 1'b1;
                        div_cmd.num = nbr_pkg::sat_sub(f_ff, pv_ff);
                        div_cmd.den = nbr_pkg::sat_sub(cur_ff, pp_ff);
                     end
                     pp_in    = cur_ff;
                     pv_in    = f_ff;
                     state_in = S_DIV;
                  end
               endcase
            end
         end

         S_DIV: begin
            if (div_done) begin
               if (sec_ff) begin
                  // second secant division: f / slope
                  sec_in        = 1'b0;
                  div_cmd.start = 1'b1;
                  div_cmd.shift = 1'b1;
                  div_cmd.num   = f_ff;
                  div_cmd.den   = div_q;
               end else begin
                  state_in = S_FIN;
                  if (probe_ff) begin
                     xn_in = nbr_pkg::sat_add(cur_ff,
                        (div_q < nbr_pkg::val_type'(1)) ? nbr_pkg::val_type'(1) : div_q);
                  end else begin
                     xn_in = nbr_pkg::sat_sub(cur_ff, div_q);
                  end
               end
            end
         end

         S_FIN: begin
            if (out_free) begin
               x   = xn_ff;
               m   = mode_ff;
               err = err_ff;
               it  = iter_ff;
               unique case (op_ff)
                  OP_HOLD: begin
                     x = cur_ff;
                  end
                  OP_FIRST: begin
                     m = nbr_pkg::MODE_NEWTON;
                     if (x <= bl_ff) begin
                        x = bl_ff;
                        m = nbr_pkg::MODE_PROBE_LO;
                     end
                     if (x >= bh_ff) begin
                        x = bh_ff;
                        m = nbr_pkg::MODE_PROBE_HI;
                     end
                     it = iter_ff + 1'b1;
                  end
                  OP_DEFAULT: begin
                     m = nbr_pkg::MODE_NEWTON;
                     if (x >= bh_ff || iter_ff >= nbr_pkg::IT_W'(lim_ff)) begin
                        x = bh_ff;
                        m = nbr_pkg::MODE_PROBE_HI;
                     end
                     if (x <= bl_ff) begin
                        x = bl_ff;
                        m = nbr_pkg::MODE_PROBE_LO;
                     end
                  end
                  OP_BRACK: begin
                     if (x >= bh_ff || x <= bl_ff || rej) begin
                        x = nbr_pkg::midpoint(bl_ff, bh_ff);
                        m = nbr_pkg::MODE_BISECT;
                     end else begin
                        m = nbr_pkg::MODE_BR_NEWTON;
                     end
                  end
                  OP_PLAIN: begin
                     x = xn_ff;
                  end
                  default: begin
                     x = cur_ff;
                  end
               endcase
               // bracket check after a regular step
               if (op_ff == OP_DEFAULT || op_ff == OP_BRACK || op_ff == OP_PLAIN) begin
                  if (nbr_pkg::same_sign(vah_ff, val_ff)) begin
                     err = nbr_pkg::ERR_NO_BRACKET;
                  end else if (iter_ff != '1) begin
                     it = iter_ff + 1'b1;
                  end
               end
               cur_in              = x;
               mode_in             = m;
               iter_in             = it;
               rsp_valid_in        = 1'b1;
               rsp_in.next_x       = x;
               rsp_in.done_res     = done_ff;
               rsp_in.error_code   = err;
               rsp_in.iteration    = it;
               state_in            = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         lb_ff        <= '0;
         ub_ff        <= nbr_pkg::val_type'(1) <<< nbr_pkg::FB;
         tol_ff       <= '0;
         lim_ff       <= nbr_pkg::LIM_W'(6);
         cur_ff       <= '0;
         pp_ff        <= '0;
         pv_ff        <= '0;
         bl_ff        <= '0;
         bh_ff        <= '0;
         val_ff       <= '0;
         vah_ff       <= '0;
         bw_ff        <= '0;
         mode_ff      <= nbr_pkg::MODE_NEWTON;
         iter_ff      <= '0;
         sec_ff       <= 1'b0;
         probe_ff     <= 1'b0;
         op_ff        <= OP_HOLD;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         lb_ff        <= lb_in;
         ub_ff        <= ub_in;
         tol_ff       <= tol_in;
         lim_ff       <= lim_in;
         cur_ff       <= cur_in;
         pp_ff        <= pp_in;
         pv_ff        <= pv_in;
         bl_ff        <= bl_in;
         bh_ff        <= bh_in;
         val_ff       <= val_in;
         vah_ff       <= vah_in;
         bw_ff        <= bw_in;
         mode_ff      <= mode_in;
         iter_ff      <= iter_in;
         sec_ff       <= sec_in;
         probe_ff     <= probe_in;
         op_ff        <= op_in;
      end
      f_ff    <= f_in;
      d_ff    <= d_in;
      xn_ff   <= xn_in;
      done_ff <= done_in;
      err_ff  <= err_in;
      rsp_ff  <= rsp_in;
      // |width * f'| for the bracketed Newton test, settles while dividing
      prod_ff <= nbr_pkg::mag(bw_ff) * nbr_pkg::mag(d_ff);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `NBR_ASSERT_NEXT(a_accept_eval, req_valid && req_ready, state_ff == S_EVAL, "request not evaluated")
   `NBR_ASSERT_IMPL(a_div_state, div_done, state_ff == S_DIV, "divider finished outside wait")
   `NBR_ASSERT_IMPL(a_done_ok, rsp_valid && rsp_data.done_res, rsp_data.error_code == nbr_pkg::ERR_OK, "done with error")

endmodule

### dv/tb_newton_bisection_root_step.sv
`timescale 1ns / 1ps

module tb_newton_bisection_root_step;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   nbr_pkg::req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   nbr_pkg::rsp_type rsp_data;
   logic    csr_we;
   logic [1:0] csr_index;
   logic [nbr_pkg::VW-1:0] csr_wdata;

   newton_bisection_root_step u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Predictor state, kept in 64-bit signed so saturation is easy to express
   localparam longint PMAX = 64'sd2147483647;
   localparam longint PMIN = -64'sd2147483648;
   localparam logic [2:0] M_NEWTON = 3'd0, M_PHI = 3'd1, M_PHIK = 3'd2, M_PLO = 3'd3,
                          M_PLOK = 3'd4, M_BRN = 3'd5, M_BIS = 3'd6;

   longint lo_bound, hi_bound, tol_cfg, lim_cfg;
   longint cur_x, prev_x, prev_f, br_lo, br_hi, f_lo, f_hi, br_w;
   logic [2:0] mode;
   int unsigned iter_cnt;

   nbr_pkg::rsp_type expected_rsps[$];
   int  errors;
   bit  idle_ok;

   function automatic longint clampv(longint v);
      if (v > PMAX) return PMAX;
      if (v < PMIN) return PMIN;
      return v;
   endfunction

   function automatic int sgn(longint v);
      return v > 0 ? 1 : (v < 0 ? -1 : 0);
   endfunction

   function automatic longint absl(longint v);
      return v < 0 ? -v : v;
   endfunction

   // (n << 16) / d, truncated toward zero, saturated
   function automatic longint qdiv(longint n, longint d);
      longint q;
      if (d == 0) return n == 0 ? 0 : (n < 0 ? PMIN : PMAX);
      q = (absl(n) << nbr_pkg::FB) / absl(d);
      if ((n < 0) != (d < 0)) q = -q;
      return clampv(q);
   endfunction

   function automatic longint mid(longint a, longint b);
      return (a + b) >>> 1;
   endfunction

   function automatic longint step_pt(longint x, longint xo, longint f, longint fo, longint d);
      if (d != 0) return clampv(x - qdiv(f, d));
      return clampv(x - qdiv(f, qdiv(clampv(f - fo), clampv(x - xo))));
   endfunction

   // 2|f| * 2^16 > |w * d|, exact in 128 bits
   function automatic bit newton_reject(longint f, longint w, longint d);
      logic [127:0] lhs, rhs;
      lhs = 128'(absl(f)) << (nbr_pkg::FB + 1);
      rhs = 128'(absl(w)) * 128'(absl(d));
      return lhs > rhs;
   endfunction

   function automatic void predict_reset();
      lo_bound = 0; hi_bound = 65536; tol_cfg = 0; lim_cfg = 6;
      cur_x = 0; prev_x = 0; prev_f = 0; br_lo = 0; br_hi = 0;
      f_lo = 0; f_hi = 0; br_w = 0; mode = M_NEWTON; iter_cnt = 0;
   endfunction

   function automatic nbr_pkg::rsp_type predict_step(nbr_pkg::req_type r);
      nbr_pkg::rsp_type o;
      longint f, d, x, xn, s;
      logic [1:0] err;
      bit done;
      f = longint'(r.f_value); d = longint'(r.derivative);
      err = nbr_pkg::ERR_OK; done = 0;
      if (r.start_req) begin
         iter_cnt = 0;
         cur_x = longint'(r.initial_guess);
      end
      x = cur_x;
      if (absl(f) <= tol_cfg) begin
         done = 1;
      end else if (iter_cnt == 0) begin
         if (lo_bound > hi_bound) err = nbr_pkg::ERR_BOUNDS;
         else if (x > hi_bound || x < lo_bound) err = nbr_pkg::ERR_GUESS;
         else begin
            br_lo = lo_bound; br_hi = hi_bound;
            br_w = clampv(br_hi - br_lo);
            f_lo = 0; f_hi = 0;
            prev_x = x; prev_f = f;
            if (d == 0) begin
               s = br_w / 10000;
               x = clampv(x + (s < 1 ? 1 : s));
            end else begin
               x = clampv(x - qdiv(f, d));
            end
            mode = M_NEWTON;
            if (x <= br_lo) begin x = br_lo; mode = M_PLO; end
            if (x >= br_hi) begin x = br_hi; mode = M_PHI; end
            cur_x = x;
            iter_cnt++;
         end
      end else begin
         case (mode)
            M_PHI: begin
               f_hi = f;
               if (sgn(f) * sgn(prev_f) < 0) begin
                  br_lo = prev_x; f_lo = prev_f; br_hi = x; f_hi = f;
                  x = mid(prev_x, x); mode = M_BRN;
               end else begin
                  br_hi = prev_x; f_hi = prev_f; x = br_lo; mode = M_PLOK;
               end
               br_w = clampv(br_hi - br_lo);
            end
            M_PHIK: begin
               f_hi = f;
               if (!(sgn(f_hi) * sgn(f_lo) > 0)) begin
                  br_lo = prev_x; f_lo = prev_f; x = mid(prev_x, x);
                  br_w = clampv(br_hi - br_lo); mode = M_BRN;
               end
            end
            M_PLO: begin
               f_lo = f;
               if (sgn(f) * sgn(prev_f) < 0) begin
                  br_hi = prev_x; f_hi = prev_f; br_lo = x; f_lo = f;
                  x = mid(prev_x, x); mode = M_BRN;
               end else begin
                  br_lo = prev_x; f_lo = prev_f; x = br_hi; mode = M_PHIK;
               end
               br_w = clampv(br_hi - br_lo);
            end
            M_PLOK: begin
               f_lo = f;
               if (!(sgn(f_lo) * sgn(f_hi) > 0)) begin
                  br_hi = prev_x; f_hi = prev_f; x = mid(prev_x, x);
                  br_w = clampv(br_hi - br_lo); mode = M_BRN;
               end
            end
            M_BRN, M_BIS: begin
               if (sgn(f_lo) * sgn(f) > 0) begin
                  br_lo = x; f_lo = f; br_w = clampv(br_hi - br_lo);
               end else if (sgn(f_hi) * sgn(f) > 0) begin
                  br_hi = x; f_hi = f; br_w = clampv(br_hi - br_lo);
               end
               xn = step_pt(x, prev_x, f, prev_f, d);
               prev_x = x; prev_f = f;
               if (xn >= br_hi || xn <= br_lo || (d != 0 && newton_reject(f, br_w, d))) begin
                  x = mid(br_lo, br_hi); mode = M_BIS;
               end else begin
                  x = xn; mode = M_BRN;
               end
            end
            default: begin
               xn = step_pt(x, prev_x, f, prev_f, d);
               prev_x = x; prev_f = f;
               x = xn; mode = M_NEWTON;
               if (x >= br_hi || longint'(iter_cnt) >= lim_cfg) begin
                  x = br_hi; mode = M_PHI;
               end
               if (x <= br_lo) begin x = br_lo; mode = M_PLO; end
            end
         endcase
         cur_x = x;
         if (sgn(f_hi) * sgn(f_lo) > 0) err = nbr_pkg::ERR_NO_BRACKET;
         else if (iter_cnt < 16'hFFFF) iter_cnt++;
      end
      o.next_x = nbr_pkg::val_type'(cur_x);
      o.done_res = done;
      o.error_code = err;
      o.iteration = iter_cnt[nbr_pkg::IT_W-1:0];
      return o;
   endfunction

   // Clock and watchdog
   initial clock = 0;
   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   initial begin
      #50ms;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic bit idle_now();
      return !idle_ok && ($urandom_range(99) < 6);
   endfunction

   // Response side: random backpressure and checking
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected response next_x=%0h", rsp_data.next_x);
               errors++;
            end else begin
               nbr_pkg::rsp_type e;
               e = expected_rsps.pop_front();
               if (e.next_x !== rsp_data.next_x) begin
                  $error("next_x exp %0d got %0d", e.next_x, rsp_data.next_x); errors++;
               end
               if (e.done_res !== rsp_data.done_res) begin
                  $error("done_res exp %0d got %0d", e.done_res, rsp_data.done_res); errors++;
               end
               if (e.error_code !== rsp_data.error_code) begin
                  $error("error_code exp %0d got %0d", e.error_code, rsp_data.error_code);
                  errors++;
               end
               if (e.iteration !== rsp_data.iteration) begin
                  $error("iteration exp %0d got %0d", e.iteration, rsp_data.iteration);
                  errors++;
               end
            end
         end
         rsp_ready <= !idle_now();
      end
   end

   // Send one request and record its prediction
   task automatic send_req(bit st, longint guess, longint f, longint d);
      nbr_pkg::req_type r;
      while (idle_now()) @(posedge clock);
      r.start_req = st;
      r.initial_guess = nbr_pkg::val_type'(guess);
      r.f_value = nbr_pkg::val_type'(f);
      r.derivative = nbr_pkg::val_type'(d);
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      expected_rsps.push_back(predict_step(r));
      req_valid <= 0;
      // the block stays busy after an accept, so the extra wait here costs nothing
      @(posedge clock);
   endtask

   task automatic write_csr(nbr_pkg::csr_index_type idx, longint v);
      csr_we <= 1; csr_index <= idx; csr_wdata <= v[nbr_pkg::VW-1:0];
      @(posedge clock);
      case (idx)
         nbr_pkg::CSR_LOWER: lo_bound = longint'(nbr_pkg::val_type'(v));
         nbr_pkg::CSR_UPPER: hi_bound = longint'(nbr_pkg::val_type'(v));
         nbr_pkg::CSR_TOL:   tol_cfg = v & 64'h7FFF_FFFF;
         default:            lim_cfg = v & 64'hFF;
      endcase
   endtask

   task automatic drain();
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic set_cfg(longint lo, longint hi, longint tol, longint lim);
      drain();
      write_csr(nbr_pkg::CSR_LOWER, lo);
      write_csr(nbr_pkg::CSR_UPPER, hi);
      write_csr(nbr_pkg::CSR_TOL, tol);
      write_csr(nbr_pkg::CSR_LIMIT, lim);
      csr_we <= 0;
   endtask

   function automatic longint rnd32();
      return longint'(nbr_pkg::val_type'($urandom));
   endfunction

   // Edge values, each operation and the named corner cases
   task automatic test_directed();
      set_cfg(-65536 * 4, 65536 * 4, 16, 6);
      send_req(1, 0, 0, 0);                        // root found at once
      send_req(1, 65536, 65536, 65536 * 2);        // Newton first step
      send_req(0, 0, 32768, 65536);
      send_req(0, 0, 1000, 0);                     // secant
      send_req(1, 65536 * 8, 500, 65536);          // guess outside bounds
      send_req(1, -65536, PMIN, PMAX);
      send_req(0, 0, PMAX, PMIN);
      send_req(0, 0, 70000, 0);
      set_cfg(65536, -65536, 0, 0);                // bounds reversed, zero limit
      send_req(1, 0, 100, 100);
      set_cfg(PMIN, PMAX, 0, 0);
      send_req(1, 0, 65536, 65536);
      send_req(0, 0, -65536, 65536);
      send_req(0, 0, 3000, 0);
      send_req(0, 0, -3000, 0);
      set_cfg(PMIN, PMAX, 64'h7FFF_FFFF, 255);     // everything within tolerance
      send_req(1, PMAX, PMIN + 1, 0);
      set_cfg(0, 0, 0, 1);                         // degenerate interval
      send_req(1, 0, 7, 0);
      send_req(0, 0, -7, 3);
      send_req(0, 0, 7, 3);
   endtask

   // Well-formed searches on a linear function, plus noise
   task automatic test_random(int n);
      int k;
      longint root, x, f, d;
      bit use_d;
      k = 0;
      while (k < n) begin
         case ($urandom_range(3))
            0: set_cfg(-65536 * 16, 65536 * 16, $urandom_range(2000), $urandom_range(1, 10));
            1: set_cfg(-($urandom_range(1, 65536 * 64)), $urandom_range(1, 65536 * 64),
                       $urandom_range(50), $urandom_range(255));
            2: set_cfg(rnd32(), rnd32(), $urandom & 32'h7FFF_FFFF, $urandom_range(255));
            default: set_cfg(lo_bound, hi_bound, tol_cfg, lim_cfg);
         endcase
         idle_ok = ($urandom_range(7) == 0);
         root = $urandom_range(0, 1) ? longint'($urandom_range(0, 65536 * 8)) :
                -longint'($urandom_range(0, 65536 * 8));
         use_d = $urandom_range(1);
         send_req(1, $urandom_range(3) == 0 ? rnd32() : root + $urandom_range(65536 * 2),
                  $urandom_range(65536), 65536);
         k++;
         repeat ($urandom_range(5, 30)) begin
            if ($urandom_range(15) == 0) begin
               send_req($urandom_range(7) == 0, rnd32(), rnd32(),
                        $urandom_range(1) ? 0 : rnd32());
            end else begin
               x = cur_x;
               f = clampv((x - root) * 3);
               d = use_d ? 65536 * 3 : 0;
               send_req(0, rnd32(), f, d);
            end
            k++;
         end
         idle_ok = 0;
      end
   endtask

   initial begin
      errors = 0; idle_ok = 0;
      predict_reset();
      reset = 1; req_valid = 0; req_data = '0;
      csr_we = 0; csr_index = nbr_pkg::CSR_LOWER; csr_wdata = '0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_random(900);
      drain();
      if (errors == 0 && expected_rsps.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end
endmodule

### newton_bisection_root_step.f
+incdir+design
design/nbr_pkg.sv
design/nbr_div.sv
design/newton_bisection_root_step.sv
dv/tb_newton_bisection_root_step.sv
